// ===== hw/rtl/oepb_pkg.sv =====
// Occluder edge plane builder: shared types and constants.
// Used by the builder unit and the testbench; depends on nothing.
package oepb_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [1:0] MODE_EYE    = 2'd0;
  localparam logic [1:0] MODE_PLANE  = 2'd1;
  localparam logic [1:0] MODE_VERTEX = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_AWAY = 2'd1;
  localparam logic [1:0] STATUS_DEG  = 2'd2;

  // 0.1 in Q32.32 units and 0.001 in units of 2^-64
  localparam logic signed [65:0] FACE_LIMIT = 66'sd429496730;
  localparam logic signed [65:0] DEG_LIMIT  = 66'sd18446744073709552;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] plane_offset;
    logic               last_vertex;
  } in_req_t;

  typedef struct packed {
    logic [4:0]         plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] offset;
    logic [1:0]         status;
    logic               last;
  } out_req_t;

endpackage

// ===== hw/rtl/oepb_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
// Depends on nothing.
module oepb_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);
  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;
endmodule

// ===== hw/rtl/oepb_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on nothing.
module oepb_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] n_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [64:0] trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r   <= radicand;
        r_r   <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if ({1'b0, n_r} >= trial) begin
          n_r <= n_r - trial[63:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule

// ===== hw/rtl/oepb_div.sv =====
// Iterative restoring divider, 32 quotient bits at one bit per cycle.
// Requires the quotient to fit 32 bits. Depends on nothing.
module oepb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r;
  logic [31:0] low_r;
  logic [31:0] den_r;
  logic [31:0] q_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_r, low_r[31]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num[63:32];
        low_r <= num[31:0];
        den_r <= den;
        q_r   <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        low_r <= low_r << 1;
        q_r   <= {q_r[30:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ===== hw/rtl/occluder_edge_plane_builder_unit.sv =====
// Occluder edge plane builder: sequencer around a shared multiplier,
// square root and divider. Depends on oepb_pkg, oepb_mul, oepb_isqrt, oepb_div.
// A plane load forms the facing dot product and emits the load plane; an edge plane
// runs difference, cross product, magnitude, shift steps, sum of squares, square root,
// three divides and the eye dot product (twelve multiplier passes); a closing vertex also emits the closing edge.
// One request at a time; stall is high while busy. Reset clears eye, vertices, count, flag.
module occluder_edge_plane_builder_unit #(
  parameter int MAX_VERTICES = oepb_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oepb_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output oepb_pkg::out_req_t out_req
);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_FACE, S_FACE_CHK, S_DIFF, S_CROSS, S_MAG, S_SHIFT,
    S_SQ, S_SQ_CHK, S_SQRT, S_DIV, S_DOT, S_DOT_FIN, S_EMIT
  } state_t;

  typedef enum logic [1:0] {OP_FACE, OP_CROSS, OP_SQ, OP_DOT} op_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_diff(input logic signed [31:0] a,
                                                   input logic signed [31:0] e);
    logic signed [32:0] d;
    d = {a[31], a} - {e[31], e};
    if (d > 33'sd2147483647) return 32'sh7FFF_FFFF;
    if (d < -33'sd2147483647) return 32'sh8000_0001;
    return d[31:0];
  endfunction

  state_t state_r;
  logic [2:0] cnt_r;
  logic [VCW-1:0] vc_r;
  logic failed_r;
  logic pend_r;
  logic signed [31:0] eye_r [3];
  logic signed [31:0] first_r [3];
  logic signed [31:0] prev_r [3];
  logic signed [31:0] cur_r [3];
  logic signed [31:0] doff_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];
  logic signed [31:0] x_r [3];
  logic signed [31:0] y_r [3];
  logic signed [63:0] c_r [3];
  logic [63:0] u_r [3];
  logic [63:0] m_r;
  logic small_r;
  logic signed [31:0] n_r [3];
  logic [31:0] len_r;
  logic signed [65:0] acc_r;
  logic [4:0] eidx_r;
  logic elast_r;
  oepb_pkg::out_req_t res_r;
  oepb_pkg::out_req_t out_req_r;
  logic out_valid_r;
  logic mul_vld_r;
  op_t mul_kind_r;
  logic [2:0] mul_idx_r;
  logic sq_start_r;
  logic div_start_r;

  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] prod;
  logic issue;
  op_t issue_kind;
  logic [1:0] ix;
  logic sq_done;
  logic [31:0] sq_root;
  logic div_done;
  logic [31:0] div_quo;
  logic [63:0] div_num;
  logic signed [31:0] vin [3];
  logic [VCW:0] vc_inc;
  logic [63:0] m_max;
  logic signed [65:0] dot_s;
  logic signed [65:0] dot_t;
  logic signed [65:0] fneg [3];
  logic out_free;

  assign vin[0] = in_req.coord_x;
  assign vin[1] = in_req.coord_y;
  assign vin[2] = in_req.coord_z;
  assign vc_inc = {1'b0, vc_r} + 1'b1;
  assign ix = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    op_a = '0;
    op_b = '0;
    issue = 1'b0;
    issue_kind = OP_FACE;
    case (state_r)
      S_FACE: begin
        op_a = cur_r[ix];
        op_b = eye_r[ix];
        issue = cnt_r < 3'd3;
      end
      S_CROSS: begin
        issue = cnt_r < 3'd6;
        issue_kind = OP_CROSS;
        case (cnt_r)
          3'd0: begin op_a = x_r[1]; op_b = y_r[2]; end
          3'd1: begin op_a = x_r[2]; op_b = y_r[1]; end
          3'd2: begin op_a = x_r[2]; op_b = y_r[0]; end
          3'd3: begin op_a = x_r[0]; op_b = y_r[2]; end
          3'd4: begin op_a = x_r[0]; op_b = y_r[1]; end
          3'd5: begin op_a = x_r[1]; op_b = y_r[0]; end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      S_SQ: begin
        op_a = u_r[ix][31:0];
        op_b = u_r[ix][31:0];
        issue = cnt_r < 3'd3;
        issue_kind = OP_SQ;
      end
      S_DOT: begin
        op_a = eye_r[ix];
        op_b = n_r[ix];
        issue = cnt_r < 3'd3;
        issue_kind = OP_DOT;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    m_max = u_r[0];
    if (u_r[1] > m_max) m_max = u_r[1];
    if (u_r[2] > m_max) m_max = u_r[2];
  end

  assign div_num = ({32'd0, u_r[ix][31:0]} << 30) + {33'd0, len_r[31:1]};
  assign dot_s = acc_r + (66'sd1 <<< 29);
  assign dot_t = dot_s >>> 30;

  for (genvar i = 0; i < 3; i++) begin : g_fneg
    assign fneg[i] = (-{{34{cur_r[i][31]}}, cur_r[i]}) <<< 14;
  end

  oepb_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  oepb_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (acc_r[63:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  oepb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num),
    .den   (len_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vc_r        <= '0;
      failed_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mul_vld_r   <= 1'b0;
      sq_start_r  <= 1'b0;
      div_start_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        eye_r[i]   <= '0;
        first_r[i] <= '0;
        prev_r[i]  <= '0;
      end
    end else begin
      sq_start_r  <= 1'b0;
      div_start_r <= 1'b0;
      mul_vld_r   <= issue;
      mul_kind_r  <= issue_kind;
      mul_idx_r   <= cnt_r;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_req.mode)
              oepb_pkg::MODE_EYE: begin
                for (int i = 0; i < 3; i++) eye_r[i] <= vin[i];
              end
              oepb_pkg::MODE_PLANE: begin
                for (int i = 0; i < 3; i++) cur_r[i] <= vin[i];
                doff_r  <= in_req.plane_offset;
                acc_r   <= {{18{in_req.plane_offset[31]}}, in_req.plane_offset, 16'd0};
                vc_r    <= '0;
                pend_r  <= 1'b0;
                cnt_r   <= '0;
                state_r <= S_FACE;
              end
              oepb_pkg::MODE_VERTEX: begin
                if (!failed_r) begin
                  if (vc_r == '0) begin
                    for (int i = 0; i < 3; i++) begin
                      first_r[i] <= vin[i];
                      prev_r[i]  <= vin[i];
                      a_r[i]     <= vin[i];
                      b_r[i]     <= vin[i];
                    end
                    vc_r    <= VCW'(1);
                    pend_r  <= 1'b0;
                    eidx_r  <= 5'd1;
                    elast_r <= 1'b1;
                    if (in_req.last_vertex) state_r <= S_DIFF;
                  end else if (vc_r < VCW'(MAX_VERTICES)) begin
                    for (int i = 0; i < 3; i++) begin
                      cur_r[i] <= vin[i];
                      a_r[i]   <= vin[i];
                      b_r[i]   <= prev_r[i];
                    end
                    pend_r  <= in_req.last_vertex;
                    eidx_r  <= 5'(vc_inc);
                    elast_r <= 1'b0;
                    state_r <= S_DIFF;
                  end else if (in_req.last_vertex) begin
                    for (int i = 0; i < 3; i++) begin
                      a_r[i] <= first_r[i];
                      b_r[i] <= prev_r[i];
                    end
                    pend_r  <= 1'b0;
                    eidx_r  <= 5'd1;
                    elast_r <= 1'b1;
                    state_r <= S_DIFF;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FACE: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) state_r <= S_FACE_CHK;
        end
        S_FACE_CHK: begin
          res_r.plane_index <= '0;
          if (acc_r < oepb_pkg::FACE_LIMIT) begin
            failed_r       <= 1'b1;
            res_r.normal_x <= '0;
            res_r.normal_y <= '0;
            res_r.normal_z <= '0;
            res_r.offset   <= '0;
            res_r.status   <= oepb_pkg::STATUS_AWAY;
            res_r.last     <= 1'b1;
          end else begin
            failed_r       <= 1'b0;
            res_r.normal_x <= sat32(fneg[0]);
            res_r.normal_y <= sat32(fneg[1]);
            res_r.normal_z <= sat32(fneg[2]);
            res_r.offset   <= sat32(-{{34{doff_r[31]}}, doff_r});
            res_r.status   <= oepb_pkg::STATUS_OK;
            res_r.last     <= 1'b0;
          end
          state_r <= S_EMIT;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            x_r[i] <= clamp_diff(a_r[i], eye_r[i]);
            y_r[i] <= clamp_diff(b_r[i], eye_r[i]);
          end
          cnt_r   <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd6) state_r <= S_MAG;
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            u_r[i] <= c_r[i][63] ? 64'(-c_r[i]) : 64'(c_r[i]);
          end
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (cnt_r == 3'd7) begin
            m_r     <= m_max;
            small_r <= m_max < 64'h1000_0000;
            cnt_r   <= '0;
          end else if (m_r[63:31] != '0) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) u_r[i] <= u_r[i] >> 1;
          end else begin
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) state_r <= S_SQ_CHK;
        end
        S_SQ_CHK: begin
          if ((small_r && acc_r < oepb_pkg::DEG_LIMIT) || acc_r == '0) begin
            res_r.plane_index <= eidx_r;
            res_r.normal_x    <= '0;
            res_r.normal_y    <= '0;
            res_r.normal_z    <= '0;
            res_r.offset      <= '0;
            res_r.status      <= oepb_pkg::STATUS_DEG;
            res_r.last        <= 1'b1;
            failed_r          <= 1'b1;
            vc_r              <= '0;
            pend_r            <= 1'b0;
            state_r           <= S_EMIT;
          end else begin
            sq_start_r <= 1'b1;
            state_r    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            len_r       <= sq_root;
            cnt_r       <= '0;
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            n_r[ix] <= c_r[ix][63] ? -$signed(div_quo) : $signed(div_quo);
            if (cnt_r == 3'd2) begin
              acc_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_DOT;
            end else begin
              cnt_r       <= cnt_r + 3'd1;
              div_start_r <= 1'b1;
            end
          end
        end
        S_DOT: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) state_r <= S_DOT_FIN;
        end
        S_DOT_FIN: begin
          res_r.plane_index <= eidx_r;
          res_r.normal_x    <= n_r[0];
          res_r.normal_y    <= n_r[1];
          res_r.normal_z    <= n_r[2];
          res_r.offset      <= sat32(-dot_t);
          res_r.status      <= oepb_pkg::STATUS_OK;
          res_r.last        <= elast_r;
          if (elast_r) begin
            vc_r <= '0;
          end else begin
            for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
            vc_r <= vc_inc[VCW-1:0];
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_req_r   <= res_r;
            out_valid_r <= 1'b1;
            if (pend_r) begin
              pend_r  <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                a_r[i] <= first_r[i];
                b_r[i] <= prev_r[i];
              end
              eidx_r  <= 5'd1;
              elast_r <= 1'b1;
              state_r <= S_DIFF;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (state_r == S_MAG) cnt_r <= 3'd7;

      if (mul_vld_r) begin
        case (mul_kind_r)
          OP_CROSS: begin
            if (!mul_idx_r[0]) acc_r <= {{2{prod[63]}}, prod};
            else c_r[mul_idx_r[2:1]] <= acc_r[63:0] - prod;
          end
          default: acc_r <= acc_r + {{2{prod[63]}}, prod};
        endcase
      end
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;
endmodule

// ===== test/tb.sv =====
// Testbench for occluder_edge_plane_builder_unit: drives eye, plane, vertex and unused-mode
// requests, predicts every clipping plane and checks the results in order.
// Depends on oepb_pkg and the occluder_edge_plane_builder_unit RTL.
`timescale 1ns / 100ps

class plane_scoreboard;
  oepb_pkg::out_req_t planes_due[$];
  longint eye[3];
  longint first_v[3];
  longint prev_v[3];
  int unsigned vcount;
  bit failed;
  int unsigned mismatches;
  int unsigned errors;

  function new();
    for (int i = 0; i < 3; i++) begin
      eye[i] = 0;
      first_v[i] = 0;
      prev_v[i] = 0;
    end
    vcount = 0;
    failed = 0;
    mismatches = 0;
    errors = 0;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [95:0] v);
    if (v > 96'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -96'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint clamp31(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh7FFFFFFF) return -64'sh7FFFFFFF;
    return v;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void push_plane(logic [4:0] idx, logic signed [31:0] nx,
                                     logic signed [31:0] ny, logic signed [31:0] nz,
                                     logic signed [31:0] off, logic [1:0] st, logic lst);
    oepb_pkg::out_req_t r;
    r.plane_index = idx;
    r.normal_x = nx;
    r.normal_y = ny;
    r.normal_z = nz;
    r.offset = off;
    r.status = st;
    r.last = lst;
    planes_due.push_back(r);
  endfunction

  // returns 1 when the edge is degenerate
  function automatic bit edge_plane(logic [4:0] idx, longint p1[3], longint p2[3], bit lst);
    longint x[3];
    longint y[3];
    longint c[3];
    logic [63:0] u[3];
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] len;
    logic signed [95:0] n[3];
    logic signed [95:0] s;
    int sh;
    for (int i = 0; i < 3; i++) begin
      x[i] = clamp31(p1[i] - eye[i]);
      y[i] = clamp31(p2[i] - eye[i]);
    end
    c[0] = x[1] * y[2] - x[2] * y[1];
    c[1] = x[2] * y[0] - x[0] * y[2];
    c[2] = x[0] * y[1] - x[1] * y[0];
    for (int i = 0; i < 3; i++) u[i] = c[i] < 0 ? -c[i] : c[i];
    m = u[0];
    if (u[1] > m) m = u[1];
    if (u[2] > m) m = u[2];
    if (m < (64'd1 << 28)) begin
      sq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      if (sq < 64'd18446744073709552) begin
        push_plane(idx, 0, 0, 0, 0, oepb_pkg::STATUS_DEG, 1'b1);
        return 1;
      end
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) u[i] = u[i] >> sh;
    sq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    len = root_floor(sq);
    if (len == 0) begin
      push_plane(idx, 0, 0, 0, 0, oepb_pkg::STATUS_DEG, 1'b1);
      return 1;
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = 96'(((u[i] << 30) + (len >> 1)) / len);
      if (c[i] < 0) n[i] = -n[i];
    end
    s = 96'(eye[0]) * n[0] + 96'(eye[1]) * n[1] + 96'(eye[2]) * n[2];
    s = (s + (96'sd1 <<< 29)) >>> 30;
    push_plane(idx, n[0][31:0], n[1][31:0], n[2][31:0], sat32(-s),
               oepb_pkg::STATUS_OK, lst);
    return 0;
  endfunction

  function automatic void note_request(oepb_pkg::in_req_t q);
    longint v[3];
    logic signed [71:0] face;
    v[0] = q.coord_x;
    v[1] = q.coord_y;
    v[2] = q.coord_z;
    if (q.mode == oepb_pkg::MODE_EYE) begin
      for (int i = 0; i < 3; i++) eye[i] = v[i];
      return;
    end
    if (q.mode == oepb_pkg::MODE_PLANE) begin
      face = 72'(q.plane_offset) * 72'sd65536;
      for (int i = 0; i < 3; i++) face = face + 72'(v[i]) * 72'(eye[i]);
      vcount = 0;
      if (face < 72'sd429496730) begin
        failed = 1;
        push_plane(0, 0, 0, 0, 0, oepb_pkg::STATUS_AWAY, 1'b1);
      end else begin
        failed = 0;
        push_plane(0, sat32(-96'(v[0]) * 16384), sat32(-96'(v[1]) * 16384),
                   sat32(-96'(v[2]) * 16384), sat32(-96'(q.plane_offset)),
                   oepb_pkg::STATUS_OK, 1'b0);
      end
      return;
    end
    if (q.mode != oepb_pkg::MODE_VERTEX || failed) return;
    if (vcount == 0) begin
      for (int i = 0; i < 3; i++) begin
        first_v[i] = v[i];
        prev_v[i] = v[i];
      end
      vcount = 1;
    end else if (vcount < oepb_pkg::MAX_VERTICES_DEF) begin
      if (edge_plane(5'(vcount + 1), v, prev_v, 1'b0)) begin
        failed = 1;
        vcount = 0;
        return;
      end
      for (int i = 0; i < 3; i++) prev_v[i] = v[i];
      vcount++;
    end
    if (q.last_vertex) begin
      if (edge_plane(5'd1, first_v, prev_v, 1'b1)) failed = 1;
      vcount = 0;
    end
  endfunction

  function automatic void check_plane(oepb_pkg::out_req_t got);
    oepb_pkg::out_req_t want;
    if (planes_due.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected plane %p", got);
      return;
    end
    want = planes_due.pop_front();
    if (got !== want) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("plane mismatch: expected %p actual %p", want, got);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEMS = 1550;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  oepb_pkg::in_req_t in_req;
  logic out_valid;
  logic out_stall;
  oepb_pkg::out_req_t out_req;

  int unsigned cycles;
  int unsigned sent;
  bit quiet;
  plane_scoreboard sb;

  occluder_edge_plane_builder_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) sb.note_request(in_req);
    if (rst_n && out_valid && !out_stall) sb.check_plane(out_req);
  end

  // long hold-off early on so the block backs up, random stalls elsewhere unless quiet
  initial begin : receiver
    int unsigned n;
    n = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n >= 3000 && n < 3400) out_stall <= 1'b1;
      else out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  task automatic send(oepb_pkg::in_req_t q);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] coord(int kind);
    case (kind)
      0: return 32'($urandom_range(0, 1 << 13)) - 32'(1 << 12);
      1: return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      default: return $urandom;
    endcase
  endfunction

  function automatic oepb_pkg::in_req_t make_req(logic [1:0] md, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z,
                                                 logic [31:0] off, logic lv);
    oepb_pkg::in_req_t q;
    q.mode = md;
    q.coord_x = x;
    q.coord_y = y;
    q.coord_z = z;
    q.plane_offset = off;
    q.last_vertex = lv;
    return q;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.planes_due.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic polygon(int nv, bit close, int kind);
    oepb_pkg::in_req_t v;
    if ($urandom_range(99) < 30)
      send(make_req(oepb_pkg::MODE_EYE, coord(kind), coord(kind), coord(kind), $urandom,
                    1'b0));
    send(make_req(oepb_pkg::MODE_PLANE, coord(0), coord(0), coord(0),
                  $urandom_range(99) < 90 ? 32'($urandom_range(1 << 20, 1 << 30)) : $urandom,
                  1'b0));
    v = make_req(oepb_pkg::MODE_VERTEX, 0, 0, 0, $urandom, 1'b0);
    for (int i = 0; i < nv; i++) begin
      if (i == 0 || $urandom_range(99) >= 4) begin
        v.coord_x = coord(kind);
        v.coord_y = coord(kind);
        v.coord_z = coord(kind);
      end
      v.plane_offset = $urandom;
      v.last_vertex = close && (i == nv - 1);
      send(v);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // vertices before any plane load, later a lone closing vertex after a plane load
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 0, 1'b1));
    send(make_req(oepb_pkg::MODE_EYE, 0, 0, 0, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_PLANE, 32'h00010000, 0, 0, 32'hFFFFFFFF, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 1, 2, 3, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_EYE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_PLANE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b1));
    send(make_req(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
    send(make_req(oepb_pkg::MODE_EYE, 0, 0, 0, 0, 1'b0));
    send(make_req(oepb_pkg::MODE_PLANE, 0, 0, 0, 32'h80000000, 1'b0));
    send(make_req(oepb_pkg::MODE_PLANE, 0, 0, 0, 32'h00010000, 1'b0));
    send(make_req(oepb_pkg::MODE_VERTEX, 32'h00010000, 0, 32'h00010000, 0, 1'b1));
    send(make_req(oepb_pkg::MODE_PLANE, 0, 0, 0, 32'h00010000, 1'b0));
    for (int i = 0; i < 18; i++)
      send(make_req(oepb_pkg::MODE_VERTEX, coord(1), coord(1), 32'h00100000, 0, i == 17));
    drain();

    while (sent < ITEMS) begin
      quiet = (sent > 600 && sent < 850);
      if (sent > 1000 && sent < 1010) drain();
      if ($urandom_range(99) < 80) begin
        polygon($urandom_range(99) < 85 ? $urandom_range(1, 8) : $urandom_range(9, 19),
                $urandom_range(99) < 90, $urandom_range(99) < 70 ? 1 :
                ($urandom_range(99) < 65 ? 0 : 2));
      end else begin
        send(make_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      $urandom, 1'($urandom)));
      end
    end
    quiet = 0;
    drain();
    if (sb.errors == 0 && sb.planes_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/oepb_pkg.sv
hw/rtl/oepb_mul.sv
hw/rtl/oepb_isqrt.sv
hw/rtl/oepb_div.sv
hw/rtl/occluder_edge_plane_builder_unit.sv
test/tb.sv
